FILE: hdl/cial_pkg.sv
// Shared types and constants for the counter interval accounting unit.
`timescale 1ns / 1ps

package cial_pkg;

    localparam int CMD_W      = 2;
    localparam int CPU_W      = 3;
    localparam int PID_W      = 22;
    localparam int CNT_W      = 64;
    localparam int CPU_SLOTS  = 1 << CPU_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    localparam logic [CNT_W-1:0] ALL_ONES = {CNT_W{1'b1}};
    // Signed readings -22 through -2 are counter read errors.
    localparam logic [CNT_W-1:0] ERR_LOW  = 64'hFFFF_FFFF_FFFF_FFEA;
    localparam logic [CNT_W-1:0] ERR_HIGH = 64'hFFFF_FFFF_FFFF_FFFE;

    typedef enum logic [CMD_W-1:0] {
        CMD_SWITCH_IN  = 2'd0,
        CMD_SWITCH_OUT = 2'd1,
        CMD_FUNC_ENTER = 2'd2,
        CMD_FUNC_EXIT  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FUNC_WINDOW_MODE = 2'd0,
        CFG_PID_FILTER_VALID = 2'd1,
        CFG_TRACED_PID       = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        cmd_t             command;
        logic [CPU_W-1:0] cpu_index;
        logic [PID_W-1:0] task_pid;
        logic [CNT_W-1:0] counter_value;
    } item_t;

    typedef struct packed {
        logic             recorded;
        logic [CNT_W-1:0] cpu_total;
        logic [CNT_W-1:0] call_count;
        logic [CNT_W-1:0] min_duration;
        logic [CNT_W-1:0] max_duration;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] start_reading;
        logic [CNT_W-1:0] interval_total;
    } cpu_entry_t;

    typedef struct packed {
        logic             start_we;
        logic [CNT_W-1:0] start_reading;
        logic             total_we;
        logic [CNT_W-1:0] interval_total;
    } bank_wr_t;

endpackage

FILE: hdl/counter_interval_accounting_unit.sv
// Top level of the counter interval accounting unit: stream ports and word registers.
// An accepted input word is held in the input register; once it fires, its result is held in the result register.
// Throughput: one word per cycle while results drain; every event does its subtract,
// add and compare combinationally between the input register and the result register.
// Reset: aresetn is synchronous and active low; it empties both registers, clears
// the configuration and window statistics, and marks every CPU begin reading invalid.
`timescale 1ns / 1ps

module counter_interval_accounting_unit #(
    parameter int NUM_CPUS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Configuration write port; index 0 window mode, 1 pid filter valid, 2 traced pid.
    input  logic                            cfg_wr_en,
    input  logic [cial_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [cial_pkg::CFG_DATA_W-1:0] cfg_wr_data,

    // Event stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: cpu_index[2:0], task_pid[24:3], counter_value[88:25], zero pad.
    input  logic [95:0]                     s_axis_tdata,
    // tuser from bit 0: command[1:0].
    input  logic [1:0]                      s_axis_tuser,

    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata from bit 0: cpu_total[63:0], call_count[127:64], min_duration[191:128],
    // max_duration[255:192].
    output logic [255:0]                    m_axis_tdata,
    // tuser from bit 0: recorded[0].
    output logic [0:0]                      m_axis_tuser
);

    logic              in_valid_reg;
    cial_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    cial_pkg::result_t out_result_reg;

    cial_pkg::item_t   s_item;
    cial_pkg::result_t core_result;
    logic              fire;

    // Unpack the incoming word into the event fields.
    always_comb begin
        s_item.command       = cial_pkg::cmd_t'(s_axis_tuser);
        s_item.cpu_index     = s_axis_tdata[2:0];
        s_item.task_pid      = s_axis_tdata[24:3];
        s_item.counter_value = s_axis_tdata[88:25];
    end

    // The held word is processed whenever the result register is free or being
    // drained in the same cycle. The input register reloads as soon as its word
    // moves on, so words enter back to back while results drain; a waiting result
    // holds off a new word only once the input register is full.
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg <= s_item;
        end
    end

    // The core reads and updates all accounting state in the cycle the word fires.
    cial_core #(
        .NUM_CPUS (NUM_CPUS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .fire         (fire),
        .item         (in_item_reg),
        .result       (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {out_result_reg.max_duration,
                              out_result_reg.min_duration,
                              out_result_reg.call_count,
                              out_result_reg.cpu_total};
    assign m_axis_tuser[0] = out_result_reg.recorded;

endmodule

FILE: hdl/cial_cpu_bank.sv
// Per-CPU begin readings and interval totals, one read and one write port.
`timescale 1ns / 1ps

module cial_cpu_bank #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [IDX_W-1:0]     index,
    input  cial_pkg::bank_wr_t   wr,
    output cial_pkg::cpu_entry_t rd
);

    logic [cial_pkg::CNT_W-1:0] start_reg [DEPTH];
    logic [cial_pkg::CNT_W-1:0] total_reg [DEPTH];
    logic                       in_range;

    // The array is small, so every entry is a flop and reset restores it at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                start_reg[i] <= cial_pkg::ALL_ONES;
                total_reg[i] <= '0;
            end
        end else begin
            if (wr.start_we) begin
                start_reg[index] <= wr.start_reading;
            end
            if (wr.total_we) begin
                total_reg[index] <= wr.interval_total;
            end
        end
    end

    // An index past the last CPU reads as the reset contents.
    assign in_range = (int'(index) < DEPTH);

    always_comb begin
        if (in_range) begin
            rd.start_reading  = start_reg[index];
            rd.interval_total = total_reg[index];
        end else begin
            rd.start_reading  = cial_pkg::ALL_ONES;
            rd.interval_total = '0;
        end
    end

endmodule

FILE: hdl/cial_core.sv
// Filtering, interval arithmetic, window statistics and configuration registers.
`timescale 1ns / 1ps

module cial_core #(
    parameter int NUM_CPUS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cial_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [cial_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            fire,
    input  cial_pkg::item_t                 item,
    output cial_pkg::result_t               result
);

    localparam int DEPTH = (NUM_CPUS < cial_pkg::CPU_SLOTS) ? NUM_CPUS : cial_pkg::CPU_SLOTS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [cial_pkg::CPU_W:0] DEPTH_L = (cial_pkg::CPU_W + 1)'(DEPTH);

    logic                         mode_reg;
    logic                         pid_valid_reg;
    logic [cial_pkg::PID_W-1:0]   traced_pid_reg;

    logic                         active_reg, active_next;
    logic [cial_pkg::CNT_W-1:0]   dur_reg, dur_next;
    logic [cial_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [cial_pkg::CNT_W-1:0]   min_reg, min_next;
    logic [cial_pkg::CNT_W-1:0]   max_reg, max_next;

    cial_pkg::cpu_entry_t         rd;
    cial_pkg::bank_wr_t           wr;
    cial_pkg::bank_wr_t           bank_wr;

    logic                         pid_ok;
    logic                         cpu_ok;
    logic                         read_err;
    logic                         end_ok;
    logic                         count_en;
    logic [cial_pkg::CNT_W-1:0]   delta;
    logic [cial_pkg::CNT_W-1:0]   total_sum;
    logic [cial_pkg::CNT_W-1:0]   dur_sum;
    logic [cial_pkg::CNT_W-1:0]   closed_dur;
    logic                         rec;

    cial_cpu_bank #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_cpu_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .index   (item.cpu_index[IDX_W-1:0]),
        .wr      (bank_wr),
        .rd      (rd)
    );

    assign bank_wr = fire ? wr : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            pid_valid_reg  <= 1'b0;
            traced_pid_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                cial_pkg::CFG_FUNC_WINDOW_MODE: mode_reg       <= cfg_wr_data[0];
                cial_pkg::CFG_PID_FILTER_VALID: pid_valid_reg  <= cfg_wr_data[0];
                cial_pkg::CFG_TRACED_PID:       traced_pid_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            dur_reg    <= '0;
            count_reg  <= '0;
            min_reg    <= cial_pkg::ALL_ONES;
            max_reg    <= '0;
        end else if (fire) begin
            active_reg <= active_next;
            dur_reg    <= dur_next;
            count_reg  <= count_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
        end
    end

    always_comb begin
        pid_ok   = pid_valid_reg && (traced_pid_reg == item.task_pid);
        cpu_ok   = ({1'b0, item.cpu_index} < DEPTH_L);
        read_err = (item.counter_value >= cial_pkg::ERR_LOW) &&
                   (item.counter_value <= cial_pkg::ERR_HIGH);
        delta    = item.counter_value - rd.start_reading;
        end_ok   = !read_err && (rd.start_reading != cial_pkg::ALL_ONES) && (delta != '0);
        count_en = !mode_reg || active_reg;
        total_sum = rd.interval_total + delta;
        dur_sum   = dur_reg + delta;

        wr          = '0;
        active_next = active_reg;
        dur_next    = dur_reg;
        count_next  = count_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        closed_dur  = dur_reg;
        rec         = 1'b0;

        if (cpu_ok) begin
            case (item.command)
                cial_pkg::CMD_SWITCH_IN: begin
                    if (count_en && pid_ok && !read_err) begin
                        wr.start_we      = 1'b1;
                        wr.start_reading = item.counter_value;
                        rec              = 1'b1;
                    end
                end
                cial_pkg::CMD_SWITCH_OUT: begin
                    if (count_en && pid_ok && end_ok) begin
                        wr.total_we       = 1'b1;
                        wr.interval_total = total_sum;
                        wr.start_we       = 1'b1;
                        wr.start_reading  = cial_pkg::ALL_ONES;
                        if (active_reg) begin
                            dur_next = dur_sum;
                        end
                        rec = 1'b1;
                    end
                end
                cial_pkg::CMD_FUNC_ENTER: begin
                    if (pid_ok) begin
                        active_next = 1'b1;
                        dur_next    = '0;
                        if (!read_err) begin
                            wr.start_we      = 1'b1;
                            wr.start_reading = item.counter_value;
                        end
                        rec = 1'b1;
                    end
                end
                cial_pkg::CMD_FUNC_EXIT: begin
                    if (pid_ok) begin
                        if (end_ok) begin
                            wr.total_we       = 1'b1;
                            wr.interval_total = total_sum;
                            wr.start_we       = 1'b1;
                            wr.start_reading  = cial_pkg::ALL_ONES;
                            if (active_reg) begin
                                closed_dur = dur_sum;
                            end
                        end
                        dur_next    = closed_dur;
                        active_next = 1'b0;
                        count_next  = count_reg + 1'b1;
                        if (closed_dur < min_reg) begin
                            min_next = closed_dur;
                        end
                        if (closed_dur > max_reg) begin
                            max_next = closed_dur;
                        end
                        rec = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        result.recorded     = rec;
        result.cpu_total    = !cpu_ok ? '0 :
                              (wr.total_we ? wr.interval_total : rd.interval_total);
        result.call_count   = count_next;
        result.min_duration = min_next;
        result.max_duration = max_next;
    end

`ifndef SYNTHESIS
    // Once a window has closed, the minimum can never exceed the maximum.
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("window minimum above maximum");

    // Window statistics move only when an item is processed.
    a_stats_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> ($stable(count_reg) && $stable(dur_reg) && $stable(active_reg)))
        else $error("window state changed without an item");

    // A matching function exit on a valid CPU closes exactly one window.
    a_exit_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && cpu_ok && pid_ok && (item.command == cial_pkg::CMD_FUNC_EXIT))
        |=> (count_reg == $past(count_reg) + 64'd1) && !active_reg)
        else $error("function exit did not close the window");

    // An event for a CPU that does not exist reports nothing for that CPU.
    a_bad_cpu: assert property (@(posedge aclk) disable iff (!aresetn)
        !cpu_ok |-> (!result.recorded && (result.cpu_total == '0) && !bank_wr.start_we
                     && !bank_wr.total_we))
        else $error("event on a missing CPU touched state");
`endif

endmodule
